// File: hw/rtl/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg: shared types and constants of the scanline window composer
// Register codes, display modes, pixel kinds and the structs that travel
// between the configuration block and the pipeline stages.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int ROW_W    = 9;
  localparam int COL_W    = 9;
  localparam int DIM_W    = 10;
  localparam int SHIFT_W  = 11;
  localparam int ADDR_W   = 20;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  // Division by three of a value below 1024 as a multiply and a shift.
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  localparam logic [DIM_W-1:0] RST_SOURCE_WIDTH  = 10'd320;
  localparam logic [DIM_W-1:0] RST_SOURCE_HEIGHT = 10'd240;

  typedef enum logic [1:0] {
    MODE_DEFAULT   = 2'd0,
    MODE_NARROW    = 2'd1,
    MODE_NARROW_43 = 2'd2,
    MODE_FRAME     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BLANK  = 2'd0,
    KIND_SOURCE = 2'd1,
    KIND_FRAME  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_MODE           = 3'd0,
    REG_SOURCE_WIDTH   = 3'd1,
    REG_SOURCE_HEIGHT  = 3'd2,
    REG_SHIFT_X        = 3'd3,
    REG_SHIFT_Y        = 3'd4,
    REG_SOURCE_PRESENT = 3'd5,
    REG_FRAME_PRESENT  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    mode_t                     mode;
    logic [DIM_W-1:0]          source_width;
    logic [DIM_W-1:0]          source_height;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic                      source_present;
    logic                      frame_present;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic              row_ok;
    logic [DIM_W-1:0]  srow;
    logic [ADDR_W-1:0] frame_addr;
  } row_info_t;

endpackage

// File: hw/rtl/swc_ifs.sv
// ----------------------------------------------------------------------------
// swc_ifs: stream channels of the scanline window composer
// The pixel position channel and the pixel source channel, each with
// valid, ready and its payload.
// ----------------------------------------------------------------------------
interface swc_in_if;
  logic                       valid;
  logic                       ready;
  logic [swc_pkg::ROW_W-1:0]  line_row;
  logic [swc_pkg::COL_W-1:0]  pixel_column;

  modport source(output valid, line_row, pixel_column, input ready);
  modport sink(input valid, line_row, pixel_column, output ready);
endinterface

interface swc_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 pixel_kind;
  logic [swc_pkg::ADDR_W-1:0] fetch_address;

  modport source(output valid, pixel_kind, fetch_address, input ready);
  modport sink(input valid, pixel_kind, fetch_address, output ready);
endinterface

// File: hw/rtl/swc_cfg_regs.sv
// ----------------------------------------------------------------------------
// swc_cfg_regs: configuration registers
// APB-style register file holding the mode, source geometry, shifts and
// buffer presence flags.
// ----------------------------------------------------------------------------
module swc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swc_pkg::CFG_AW-1:0] paddr,
  input  logic [swc_pkg::CFG_DW-1:0] pwdata,
  output logic [swc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output swc_pkg::cfg_t              cfg
);
  import swc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MODE:           cfg_nxt.mode           = mode_t'(pwdata[1:0]);
        REG_SOURCE_WIDTH:   cfg_nxt.source_width   = pwdata[DIM_W-1:0];
        REG_SOURCE_HEIGHT:  cfg_nxt.source_height  = pwdata[DIM_W-1:0];
        REG_SHIFT_X:        cfg_nxt.shift_x        = $signed(pwdata[SHIFT_W-1:0]);
        REG_SHIFT_Y:        cfg_nxt.shift_y        = $signed(pwdata[SHIFT_W-1:0]);
        REG_SOURCE_PRESENT: cfg_nxt.source_present = pwdata[0];
        REG_FRAME_PRESENT:  cfg_nxt.frame_present  = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:           prdata = CFG_DW'(cfg_r.mode);
      REG_SOURCE_WIDTH:   prdata = CFG_DW'(cfg_r.source_width);
      REG_SOURCE_HEIGHT:  prdata = CFG_DW'(cfg_r.source_height);
      REG_SHIFT_X:        prdata = CFG_DW'($unsigned(cfg_r.shift_x));
      REG_SHIFT_Y:        prdata = CFG_DW'($unsigned(cfg_r.shift_y));
      REG_SOURCE_PRESENT: prdata = CFG_DW'(cfg_r.source_present);
      REG_FRAME_PRESENT:  prdata = CFG_DW'(cfg_r.frame_present);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= MODE_DEFAULT;
      cfg_r.source_width   <= RST_SOURCE_WIDTH;
      cfg_r.source_height  <= RST_SOURCE_HEIGHT;
      cfg_r.shift_x        <= '0;
      cfg_r.shift_y        <= '0;
      cfg_r.source_present <= 1'b0;
      cfg_r.frame_present  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hw/rtl/swc_row_stage.sv
// ----------------------------------------------------------------------------
// swc_row_stage: input register and row resolution
// Registers the incoming pixel position, scales and shifts the row, checks it
// against the source height and forms the framebuffer address.
// ----------------------------------------------------------------------------
module swc_row_stage #(
  parameter int LINE_PIXELS = 320
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swc_pkg::cfg_t        cfg,
  swc_in_if.sink               in_bus,
  output logic                 mid_valid,
  input  logic                 mid_ready,
  output swc_pkg::row_info_t   mid
);
  import swc_pkg::*;

  logic               in_v_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic               mid_v_r;
  row_info_t          mid_r;
  row_info_t          mid_nxt;
  logic               in_adv;
  logic [ADDR_W-1:0]  div_prod;
  logic [ROW_W-1:0]   scaled;
  logic signed [DIM_W+1:0] srow;

  assign in_adv       = !mid_v_r || mid_ready;
  assign in_bus.ready = !in_v_r || in_adv;
  assign mid_valid    = mid_v_r;
  assign mid          = mid_r;

  always_comb begin
    div_prod = ADDR_W'({row_r, 1'b0}) * ADDR_W'(DIV3_MUL);
    if (cfg.mode == MODE_NARROW_43) begin
      scaled = div_prod[DIV3_SHIFT +: ROW_W];
    end else begin
      scaled = row_r;
    end
    srow = $signed({3'b000, scaled}) - $signed({cfg.shift_y[SHIFT_W-1], cfg.shift_y});
    mid_nxt.col        = col_r;
    mid_nxt.row_ok     = !srow[DIM_W+1] && (srow[DIM_W:0] < {1'b0, cfg.source_height});
    mid_nxt.srow       = srow[DIM_W-1:0];
    mid_nxt.frame_addr = ADDR_W'(row_r) * ADDR_W'(LINE_PIXELS) + ADDR_W'(col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
    end else begin
      if (in_bus.ready) begin
        in_v_r <= in_bus.valid;
      end
      if (in_adv) begin
        mid_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      row_r <= in_bus.line_row;
      col_r <= in_bus.pixel_column;
    end
    if (in_adv && in_v_r) begin
      mid_r <= mid_nxt;
    end
  end

endmodule

// File: hw/rtl/swc_addr_stage.sv
// ----------------------------------------------------------------------------
// swc_addr_stage: window placement and result register
// Places the source window on the line, decides the pixel kind, forms the
// fetch address and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module swc_addr_stage #(
  parameter int LINE_PIXELS  = 320,
  parameter int NARROW_WIDTH = 160,
  parameter int NARROW_START = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swc_pkg::cfg_t        cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  swc_pkg::row_info_t   up,
  swc_out_if.source            out_bus
);
  import swc_pkg::*;

  localparam int XW = $clog2(LINE_PIXELS + 1025) + 1;

  logic              out_v_r;
  logic [1:0]        kind_r;
  logic [1:0]        kind_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] addr_nxt;

  logic              doubled;
  logic [XW-1:0]     lp;
  logic [XW-1:0]     pixels;
  logic [XW-1:0]     outw_raw;
  logic [XW-1:0]     outw;
  logic [XW-1:0]     room;
  logic [XW-1:0]     left_sh;
  logic [XW-1:0]     left;
  logic [XW-1:0]     colx;
  logic [XW-1:0]     off;
  logic [XW-1:0]     sx;
  logic              in_win;
  logic              on_line;
  logic [ADDR_W-1:0] start;
  logic [ADDR_W-1:0] row_base;

  assign up_ready      = !out_v_r || out_bus.ready;
  assign out_bus.valid = out_v_r;
  assign out_bus.pixel_kind    = kind_r;
  assign out_bus.fetch_address = addr_r;

  always_comb begin
    doubled = (cfg.mode == MODE_NARROW_43);
    lp      = XW'(LINE_PIXELS);
    if (cfg.mode == MODE_DEFAULT) begin
      pixels = (XW'(cfg.source_width) < lp) ? XW'(cfg.source_width) : lp;
      start  = '0;
    end else begin
      pixels = XW'(NARROW_WIDTH);
      start  = ADDR_W'(NARROW_START);
    end
    outw_raw = doubled ? (pixels << 1) : pixels;
    outw     = (outw_raw > lp) ? lp : outw_raw;
    room     = lp - outw;
    if (!cfg.shift_x[SHIFT_W-1] && (cfg.shift_x != '0)) begin
      left_sh = (room >> 1) + XW'(cfg.shift_x[SHIFT_W-2:0]);
    end else begin
      left_sh = room >> 1;
    end
    left     = (left_sh > room) ? room : left_sh;
    colx     = XW'(up.col);
    on_line  = colx < lp;
    in_win   = (colx >= left) && (colx < left + outw);
    off      = colx - left;
    sx       = doubled ? (off >> 1) : off;
    row_base = ADDR_W'(up.srow) * ADDR_W'(cfg.source_width);

    kind_nxt = KIND_BLANK;
    addr_nxt = '0;
    priority if (!on_line) begin
      kind_nxt = KIND_BLANK;
    end else if (cfg.mode == MODE_FRAME) begin
      if (cfg.frame_present) begin
        kind_nxt = KIND_FRAME;
        addr_nxt = up.frame_addr;
      end
    end else if (cfg.source_present && up.row_ok && in_win) begin
      kind_nxt = KIND_SOURCE;
      addr_nxt = row_base + start + ADDR_W'(sx);
    end else begin
      kind_nxt = KIND_BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (up_ready) begin
      out_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      kind_r <= kind_nxt;
      addr_r <= addr_nxt;
    end
  end

endmodule

// File: hw/rtl/scanline_window_compose_core.sv
// ----------------------------------------------------------------------------
// scanline_window_compose_core: pixel source resolver for a video line
// Top level joining the configuration registers and the two pipeline stages.
// ----------------------------------------------------------------------------
// Each beat on the input channel names one output pixel by line row and
// column; the block answers with one beat telling whether the pixel is blank,
// a source buffer pixel or a framebuffer pixel, and its byte address. The
// pipeline has three registers (input, row resolution, result), and a beat
// passes through them in that order; one beat is accepted every clock cycle
// as long as the result side keeps taking beats.
// Write the configuration registers only while no beats are in flight.
module scanline_window_compose_core #(
  parameter int LINE_PIXELS  = 320,
  parameter int NARROW_WIDTH = 160,
  parameter int NARROW_START = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  swc_in_if.sink                     in_bus,
  swc_out_if.source                  out_bus,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swc_pkg::CFG_AW-1:0] paddr,
  input  logic [swc_pkg::CFG_DW-1:0] pwdata,
  output logic [swc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import swc_pkg::*;

  cfg_t      cfg;
  row_info_t mid;
  logic      mid_valid;
  logic      mid_ready;

  swc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swc_row_stage #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_bus    (in_bus),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  swc_addr_stage #(
    .LINE_PIXELS  (LINE_PIXELS),
    .NARROW_WIDTH (NARROW_WIDTH),
    .NARROW_START (NARROW_START)
  ) u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up       (mid),
    .out_bus  (out_bus)
  );

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for scanline_window_compose_core
// Writes the mode, window and shift registers over the APB port, streams
// pixel positions in with random gaps and stalls, and checks every result
// beat against a predictor that resolves each position to a blank, source
// buffer or framebuffer pixel with its byte address.
// ----------------------------------------------------------------------------
module testbench;
  import swc_pkg::*;

  localparam int LINE_PIXELS    = 320;
  localparam int NARROW_WIDTH   = 160;
  localparam int NARROW_START   = 48;
  localparam int PIXEL_TARGET   = 800;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
  } pixel_src_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  swc_in_if  in_bus();
  swc_out_if out_bus();

  scanline_window_compose_core #(
    .LINE_PIXELS(LINE_PIXELS),
    .NARROW_WIDTH(NARROW_WIDTH),
    .NARROW_START(NARROW_START)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  mode_t                     cur_mode;
  logic [DIM_W-1:0]          cur_width;
  logic [DIM_W-1:0]          cur_height;
  logic signed [SHIFT_W-1:0] cur_shift_x;
  logic signed [SHIFT_W-1:0] cur_shift_y;
  logic                      source_on;
  logic                      frame_on;

  pixel_src_t pixel_expect_q[$];
  int  fail_count;
  int  pixels_sent;
  int  reg_writes;
  int  quiet_cycles;
  int  stall_left;
  bit  pace_on;

  always #1 clk = ~clk;

  function automatic pixel_src_t resolve_pixel(logic [ROW_W-1:0] row,
                                                logic [COL_W-1:0] col);
    pixel_src_t res;
    bit doubled;
    int scaled, srow, first, pixels, span, room, left, offset, addr;
    res.kind = KIND_BLANK;
    res.addr = '0;
    doubled = (cur_mode == MODE_NARROW_43);
    if (int'(col) < LINE_PIXELS) begin
      if (cur_mode == MODE_FRAME) begin
        if (frame_on) begin
          addr = int'(row) * LINE_PIXELS + int'(col);
          res.kind = KIND_FRAME;
          res.addr = ADDR_W'(addr);
        end
      end else if (source_on) begin
        scaled = doubled ? (int'(row) * 2) / 3 : int'(row);
        srow = scaled - int'(cur_shift_y);
        if (srow >= 0 && srow < int'(cur_height)) begin
          if (cur_mode == MODE_DEFAULT) begin
            first = 0;
            pixels = (int'(cur_width) < LINE_PIXELS) ? int'(cur_width) : LINE_PIXELS;
          end else begin
            first = NARROW_START;
            pixels = NARROW_WIDTH;
          end
          span = doubled ? pixels * 2 : pixels;
          if (span > LINE_PIXELS) span = LINE_PIXELS;
          room = LINE_PIXELS - span;
          left = room / 2;
          if (cur_shift_x > 0) begin
            left += int'(cur_shift_x);
            if (left > room) left = room;
          end
          if (int'(col) >= left && int'(col) < left + span) begin
            offset = int'(col) - left;
            if (doubled) offset = offset / 2;
            addr = srow * int'(cur_width) + first + offset;
            res.kind = KIND_SOURCE;
            res.addr = ADDR_W'(addr);
          end
        end
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!pace_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_size();
    int picks[10] = '{0, 1, 160, 239, 240, 319, 320, 321, 511, 1023};
    if ($urandom_range(0, 9) < 4) return picks[$urandom_range(0, 9)];
    return $urandom_range(1, 1023);
  endfunction

  function automatic int pick_shift();
    int picks[7] = '{-1024, -1, 0, 1, 80, 160, 1023};
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return int'($urandom_range(0, 128)) - 64;
    if (r < 7) return picks[$urandom_range(0, 6)];
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  task automatic write_reg(reg_idx_t idx, int value);
    logic [CFG_DW-1:0] field;
    case (idx)
      REG_MODE:                         field = value & 32'h3;
      REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT: field = value & 32'h3ff;
      REG_SHIFT_X, REG_SHIFT_Y:         field = value & 32'h7ff;
      default:                          field = value & 32'h1;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= field;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MODE:           cur_mode = mode_t'(field[1:0]);
      REG_SOURCE_WIDTH:   cur_width = field[DIM_W-1:0];
      REG_SOURCE_HEIGHT:  cur_height = field[DIM_W-1:0];
      REG_SHIFT_X:        cur_shift_x = field[SHIFT_W-1:0];
      REG_SHIFT_Y:        cur_shift_y = field[SHIFT_W-1:0];
      REG_SOURCE_PRESENT: source_on = field[0];
      REG_FRAME_PRESENT:  frame_on = field[0];
      default:            ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_pixel(int row, int col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.line_row     <= row[ROW_W-1:0];
    in_bus.pixel_column <= col[COL_W-1:0];
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pixel_expect_q.push_back(resolve_pixel(row[ROW_W-1:0], col[COL_W-1:0]));
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_no_buffer();
    send_pixel(0, 0);
    send_pixel(511, 319);
    send_pixel(100, 320);
    wait_idle();
    write_reg(REG_MODE, MODE_FRAME);
    send_pixel(5, 5);
  endtask

  task automatic test_frame_passthrough();
    wait_idle();
    write_reg(REG_FRAME_PRESENT, 1);
    send_pixel(0, 0);
    send_pixel(511, 319);
    send_pixel(511, 511);
  endtask

  task automatic test_window_edges();
    wait_idle();
    write_reg(REG_MODE, MODE_DEFAULT);
    write_reg(REG_SOURCE_PRESENT, 1);
    write_reg(REG_SOURCE_WIDTH, 1023);
    write_reg(REG_SOURCE_HEIGHT, 1023);
    write_reg(REG_SHIFT_Y, -512);
    send_pixel(511, 0);
    send_pixel(511, 319);
    wait_idle();
    write_reg(REG_MODE, MODE_NARROW);
    write_reg(REG_SOURCE_WIDTH, 200);
    write_reg(REG_SOURCE_HEIGHT, 240);
    write_reg(REG_SHIFT_Y, 0);
    send_pixel(10, 79);
    send_pixel(10, 80);
    send_pixel(10, 239);
    send_pixel(10, 240);
    wait_idle();
    write_reg(REG_SHIFT_X, 1023);
    send_pixel(20, 159);
    send_pixel(20, 319);
    wait_idle();
    write_reg(REG_SHIFT_X, -1024);
    send_pixel(30, 80);
    wait_idle();
    write_reg(REG_MODE, MODE_NARROW_43);
    write_reg(REG_SHIFT_X, 0);
    send_pixel(3, 0);
    send_pixel(3, 319);
  endtask

  task automatic test_row_limits();
    wait_idle();
    write_reg(REG_MODE, MODE_DEFAULT);
    write_reg(REG_SOURCE_WIDTH, 0);
    send_pixel(10, 10);
    wait_idle();
    write_reg(REG_SOURCE_WIDTH, 320);
    write_reg(REG_SOURCE_HEIGHT, 0);
    send_pixel(0, 160);
    wait_idle();
    write_reg(REG_SOURCE_HEIGHT, 240);
    write_reg(REG_SHIFT_Y, 1023);
    send_pixel(0, 160);
    wait_idle();
    write_reg(REG_SHIFT_Y, 0);
    send_pixel(239, 160);
    send_pixel(240, 160);
  endtask

  task automatic test_random_traffic();
    int phase_len, run_len, row, col;
    while (pixels_sent < PIXEL_TARGET) begin
      wait_idle();
      pace_on = ($urandom_range(0, 3) != 0);
      write_reg(REG_MODE, $urandom_range(0, 3));
      write_reg(REG_SOURCE_WIDTH, pick_size());
      write_reg(REG_SOURCE_HEIGHT, pick_size());
      write_reg(REG_SHIFT_X, pick_shift());
      write_reg(REG_SHIFT_Y, pick_shift());
      write_reg(REG_SOURCE_PRESENT, $urandom_range(0, 9) != 0);
      write_reg(REG_FRAME_PRESENT, $urandom_range(0, 9) != 0);
      phase_len = $urandom_range(30, 80);
      while (phase_len > 0) begin
        if ($urandom_range(0, 9) < 7) begin
          row = $urandom_range(0, 511);
          col = $urandom_range(0, 300);
          run_len = $urandom_range(8, 48);
          while (run_len > 0 && col <= 511 && phase_len > 0) begin
            send_pixel(row, col);
            col++;
            run_len--;
            phase_len--;
          end
        end else begin
          send_pixel($urandom_range(0, 511), $urandom_range(0, 511));
          phase_len--;
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      out_bus.ready <= 1'b1;
      if (pace_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    pixel_src_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pixel_expect_q.size() == 0) begin
        $error("result beat with no pixel pending: kind %0d, address %0h",
               out_bus.pixel_kind, out_bus.fetch_address);
        fail_count++;
      end else begin
        want = pixel_expect_q.pop_front();
        if (out_bus.pixel_kind !== want.kind) begin
          $error("pixel_kind: expected %0d, got %0d", want.kind, out_bus.pixel_kind);
          fail_count++;
        end
        if (out_bus.fetch_address !== want.addr) begin
          $error("fetch_address: expected %0h, got %0h", want.addr, out_bus.fetch_address);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no beat accepted for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.line_row = '0;
    in_bus.pixel_column = '0;
    out_bus.ready = 1'b0;
    cur_mode = MODE_DEFAULT;
    cur_width = RST_SOURCE_WIDTH;
    cur_height = RST_SOURCE_HEIGHT;
    cur_shift_x = '0;
    cur_shift_y = '0;
    source_on = 1'b0;
    frame_on = 1'b0;
    fail_count = 0;
    pixels_sent = 0;
    reg_writes = 0;
    quiet_cycles = 0;
    stall_left = 0;
    pace_on = 1'b1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_no_buffer();
    test_frame_passthrough();
    test_window_edges();
    test_row_limits();
    test_random_traffic();
    wait_idle();
    $display("Resolved %0d pixel positions over %0d register writes in all four modes,",
             pixels_sent, reg_writes);
    $display("covering borders, shift clamps, row limits and off-line columns with stalls.");
    if (fail_count == 0 && pixel_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
